[rtl/core/assert_macros.svh]
// assertion macros used by the checker file iprhpd_checker.sv
// no dependencies; included by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check, masked while reset is asserted
`define CHK_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("concurrent check failed");

// concurrent check that also holds through reset
`define CHK_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("concurrent check failed");

`endif

[rtl/core/iprhpd_pkg.sv]
// shared types, constants and the poll-time table of the ipi rate halt-poll decider
// no dependencies; used by every rtl module through scoped names
`default_nettype none

package iprhpd_pkg;

    localparam int unsigned DataW   = 32;
    localparam int unsigned CfgW    = 16;
    localparam int unsigned LimitW  = 7;
    localparam int unsigned PollW   = 31;
    localparam int unsigned IdxW    = 2;
    localparam int unsigned CntW    = 5;
    localparam int unsigned InDataW  = 64;
    localparam int unsigned OutDataW = 72;

    // register indexes of the configuration port
    localparam logic [IdxW-1:0] RegRateThreshold = 2'd0;
    localparam logic [IdxW-1:0] RegMaxInterval   = 2'd1;
    localparam logic [IdxW-1:0] RegSampleLimit   = 2'd2;

    localparam logic [CfgW-1:0]   RstRateThreshold = 16'd400;
    localparam logic [CfgW-1:0]   RstMaxInterval   = 16'd1000;
    localparam logic [LimitW-1:0] RstSampleLimit   = 7'd100;

    // item kinds
    localparam logic KindSample = 1'b0;
    localparam logic KindClear  = 1'b1;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_CHECK = 6'b000010,
        ST_MUL   = 6'b000100,
        ST_CMP   = 6'b001000,
        ST_DIV   = 6'b010000,
        ST_OUT   = 6'b100000
    } t_state;

    typedef struct packed {
        logic start;
    } t_div_ctl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_sts;

    function automatic logic [PollW-1:0] poll_for_rate(input logic [DataW-1:0] rate);
        logic [PollW-1:0] res;
        priority if (rate > 32'd20000) res = 31'd2000000000;
        else if (rate > 32'd10000)     res = 31'd1000000000;
        else if (rate > 32'd8000)      res = 31'd500000000;
        else if (rate > 32'd6000)      res = 31'd200000000;
        else if (rate > 32'd4000)      res = 31'd50000000;
        else if (rate > 32'd2000)      res = 31'd20000000;
        else                           res = '0;
        return res;
    endfunction

endpackage

`default_nettype wire

[rtl/core/iprhpd_div.sv]
// bit-serial restoring divider, one quotient bit per cycle
// depends on iprhpd_pkg
`default_nettype none

module iprhpd_div (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire iprhpd_pkg::t_div_ctl        i_ctl,
    input  wire logic [iprhpd_pkg::DataW-1:0] i_dividend,
    input  wire logic [iprhpd_pkg::DataW-1:0] i_divisor,
    output iprhpd_pkg::t_div_sts             o_sts,
    output logic [iprhpd_pkg::DataW-1:0]     o_quotient
);

    logic                          r_busy;
    logic                          r_done;
    logic [iprhpd_pkg::CntW-1:0]   r_cnt;
    logic [iprhpd_pkg::DataW-1:0]  r_rem;
    logic [iprhpd_pkg::DataW-1:0]  r_quo;
    logic [iprhpd_pkg::DataW-1:0]  r_dsr;
    logic [iprhpd_pkg::DataW-1:0]  n_rem;
    logic [iprhpd_pkg::DataW-1:0]  n_quo;
    logic [iprhpd_pkg::DataW:0]    w_trial;
    logic [iprhpd_pkg::DataW:0]    w_diff;
    logic                          w_ge;

    // shift the next dividend bit into the partial remainder and try a subtract
    always_comb begin
        w_trial = {r_rem, r_quo[iprhpd_pkg::DataW-1]};
        w_diff  = w_trial - {1'b0, r_dsr};
        w_ge    = !w_diff[iprhpd_pkg::DataW];
        n_rem   = w_ge ? w_diff[iprhpd_pkg::DataW-1:0] : w_trial[iprhpd_pkg::DataW-1:0];
        n_quo   = {r_quo[iprhpd_pkg::DataW-2:0], w_ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '1;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dsr <= i_divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_quotient = r_quo;

endmodule

`default_nettype wire

[rtl/core/ipi_rate_halt_poll_decider_unit.sv]
// top level of the ipi rate halt-poll decider: sequencer, batch state, config
// depends on iprhpd_pkg and iprhpd_div
//
// channel  | dir | handshake                          | payload
// ---------+-----+------------------------------------+-----------------------------
// s_axis   | in  | i_s_axis_tvalid / o_s_axis_tready  | tdata stamp, count; tuser kind
// m_axis   | out | o_m_axis_tvalid / i_m_axis_tready  | tdata accepted, peak, poll, full
// cfg      | in  | i_cfg_we                           | i_cfg_idx, i_cfg_data
//
// a clear item goes from idle straight to the output state; a sample on a full batch passes
// the check state first; a rejected sample or one with zero interval also passes the multiply
// and compare states; an accepted sample with nonzero interval then waits for the 32-step divider
// synchronous active-low reset; batch state clears to zero, registers to their defaults
// the input side stays not ready while an item is in work; a stalled result holds in the
// output register and the next item is taken meanwhile, waiting only at its own result
`default_nettype none

module ipi_rate_halt_poll_decider_unit (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // stamp_seconds [31:0], ipi_count [63:32]
    input  wire logic [iprhpd_pkg::InDataW-1:0]    i_s_axis_tdata,
    // kind [0]
    input  wire logic                              i_s_axis_tuser,
    input  wire logic                              i_s_axis_tvalid,
    output logic                                   o_s_axis_tready,
    // accepted [0], peak_rate [32:1], poll_ns [63:33], batch_full [64], zero [71:65]
    output logic [iprhpd_pkg::OutDataW-1:0]        o_m_axis_tdata,
    output logic                                   o_m_axis_tvalid,
    input  wire logic                              i_m_axis_tready,
    input  wire logic                              i_cfg_we,
    input  wire logic [iprhpd_pkg::IdxW-1:0]       i_cfg_idx,
    input  wire logic [iprhpd_pkg::CfgW-1:0]       i_cfg_data
);

    localparam int unsigned DW = iprhpd_pkg::DataW;

    iprhpd_pkg::t_state r_state, n_state;

    logic [iprhpd_pkg::CfgW-1:0]   r_thr;
    logic [iprhpd_pkg::CfgW-1:0]   r_maxiv;
    logic [iprhpd_pkg::LimitW-1:0] r_limit;

    logic [DW-1:0]                 r_prev, n_prev;
    logic [iprhpd_pkg::LimitW-1:0] r_taken, n_taken;
    logic [DW-1:0]                 r_peak, n_peak;

    logic                          r_kind;
    logic [DW-1:0]                 r_stamp;
    logic [DW-1:0]                 r_count;
    logic [DW-1:0]                 r_interval, n_interval;
    logic                          r_ok_pre, n_ok_pre;
    logic [DW-1:0]                 r_prod, n_prod;
    logic                          r_acc, n_acc;

    logic                          r_out_valid, n_out_valid;
    logic [iprhpd_pkg::OutDataW-1:0] r_out_data;

    logic                          w_in_req;
    logic                          w_out_load;
    logic [DW-1:0]                 w_interval;
    logic                          w_full;

    iprhpd_pkg::t_div_ctl          w_div_ctl;
    iprhpd_pkg::t_div_sts          w_div_sts;
    logic [DW-1:0]                 w_quo;

    assign o_s_axis_tready = (r_state == iprhpd_pkg::ST_IDLE);
    assign w_in_req        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_interval      = r_stamp - r_prev;
    assign w_full          = (r_taken >= r_limit);
    assign w_out_load      = (r_state == iprhpd_pkg::ST_OUT) &&
                             (!r_out_valid || i_m_axis_tready);

    iprhpd_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_div_ctl),
        .i_dividend (r_count),
        .i_divisor  (r_interval),
        .o_sts      (w_div_sts),
        .o_quotient (w_quo)
    );

    always_comb begin
        n_state     = r_state;
        n_prev      = r_prev;
        n_taken     = r_taken;
        n_peak      = r_peak;
        n_interval  = r_interval;
        n_ok_pre    = r_ok_pre;
        n_prod      = r_prod;
        n_acc       = r_acc;
        n_out_valid = r_out_valid && !i_m_axis_tready;
        w_div_ctl   = '0;
        unique case (r_state)
            iprhpd_pkg::ST_IDLE: begin
                if (w_in_req) begin
                    n_acc = 1'b0;
                    if (i_s_axis_tuser == iprhpd_pkg::KindClear) begin
                        n_prev  = '0;
                        n_taken = '0;
                        n_peak  = '0;
                        n_state = iprhpd_pkg::ST_OUT;
                    end else begin
                        n_state = iprhpd_pkg::ST_CHECK;
                    end
                end
            end
            iprhpd_pkg::ST_CHECK: begin
                // a full batch leaves all state untouched
                if (w_full) begin
                    n_state = iprhpd_pkg::ST_OUT;
                end else begin
                    n_interval = w_interval;
                    n_ok_pre   = (r_prev != '0) && (r_stamp >= r_prev) &&
                                 (w_interval < {{(DW-iprhpd_pkg::CfgW){1'b0}}, r_maxiv});
                    n_state    = iprhpd_pkg::ST_MUL;
                end
            end
            iprhpd_pkg::ST_MUL: begin
                // exact whenever the interval passed the max-interval check
                n_prod  = {{(DW-iprhpd_pkg::CfgW){1'b0}}, r_thr} *
                          {{(DW-iprhpd_pkg::CfgW){1'b0}}, r_interval[iprhpd_pkg::CfgW-1:0]};
                n_state = iprhpd_pkg::ST_CMP;
            end
            iprhpd_pkg::ST_CMP: begin
                n_prev  = r_stamp;
                n_state = iprhpd_pkg::ST_OUT;
                if (r_ok_pre && (r_count > r_prod)) begin
                    n_acc   = 1'b1;
                    n_taken = r_taken + 1'b1;
                    if (r_interval != '0) begin
                        w_div_ctl.start = 1'b1;
                        n_state         = iprhpd_pkg::ST_DIV;
                    end
                end
            end
            iprhpd_pkg::ST_DIV: begin
                if (w_div_sts.done) begin
                    if (w_quo > r_peak) begin
                        n_peak = w_quo;
                    end
                    n_state = iprhpd_pkg::ST_OUT;
                end
            end
            iprhpd_pkg::ST_OUT: begin
                if (w_out_load) begin
                    n_out_valid = 1'b1;
                    n_state     = iprhpd_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = iprhpd_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= iprhpd_pkg::ST_IDLE;
            r_prev      <= '0;
            r_taken     <= '0;
            r_peak      <= '0;
            r_acc       <= 1'b0;
            r_out_valid <= 1'b0;
            r_thr       <= iprhpd_pkg::RstRateThreshold;
            r_maxiv     <= iprhpd_pkg::RstMaxInterval;
            r_limit     <= iprhpd_pkg::RstSampleLimit;
        end else begin
            r_state     <= n_state;
            r_prev      <= n_prev;
            r_taken     <= n_taken;
            r_peak      <= n_peak;
            r_acc       <= n_acc;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    iprhpd_pkg::RegRateThreshold: r_thr   <= i_cfg_data;
                    iprhpd_pkg::RegMaxInterval:   r_maxiv <= i_cfg_data;
                    iprhpd_pkg::RegSampleLimit:   r_limit <= i_cfg_data[iprhpd_pkg::LimitW-1:0];
                    default: ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_in_req) begin
            r_kind  <= i_s_axis_tuser;
            r_stamp <= i_s_axis_tdata[DW-1:0];
            r_count <= i_s_axis_tdata[2*DW-1:DW];
        end
        r_interval <= n_interval;
        r_ok_pre   <= n_ok_pre;
        r_prod     <= n_prod;
        if (w_out_load) begin
            r_out_data <= {{(iprhpd_pkg::OutDataW-DW-iprhpd_pkg::PollW-2){1'b0}},
                           w_full,
                           iprhpd_pkg::poll_for_rate(r_peak),
                           r_peak,
                           r_acc && (r_kind == iprhpd_pkg::KindSample)};
        end
    end

    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tvalid = r_out_valid;

endmodule

`default_nettype wire

[rtl/core/iprhpd_checker.sv]
// port-level checks on the ipi rate halt-poll decider, bound to its top level
// depends on iprhpd_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module iprhpd_checker (
    input wire logic                              i_clk,
    input wire logic                              i_rst_n,
    input wire logic                              i_s_axis_tvalid,
    input wire logic                              o_s_axis_tready,
    input wire logic [iprhpd_pkg::OutDataW-1:0]   o_m_axis_tdata,
    input wire logic                              o_m_axis_tvalid,
    input wire logic                              i_m_axis_tready
);

    logic w_in_req;
    assign w_in_req = i_s_axis_tvalid && o_s_axis_tready;

    // a taken request keeps the input side busy in the next cycle
    `CHK_ASSERT(a_busy_after_req, i_clk, i_rst_n, w_in_req |=> !o_s_axis_tready)

    // poll time always follows the reported peak through the table
    `CHK_ASSERT(a_poll_matches_peak, i_clk, i_rst_n, o_m_axis_tvalid |-> (o_m_axis_tdata[63:33] == iprhpd_pkg::poll_for_rate(o_m_axis_tdata[32:1])))

    // padding bits stay zero
    `CHK_ASSERT(a_pad_zero, i_clk, i_rst_n, o_m_axis_tvalid |-> (o_m_axis_tdata[71:65] == '0))

    // a stalled result holds
    `CHK_ASSERT(a_out_hold, i_clk, i_rst_n, (o_m_axis_tvalid && !i_m_axis_tready) |=> (o_m_axis_tvalid && $stable(o_m_axis_tdata)))

    // no result is shown right after reset
    `CHK_ASSERT_ALWAYS(a_rst_no_valid, i_clk, !i_rst_n |=> !o_m_axis_tvalid)

endmodule

bind ipi_rate_halt_poll_decider_unit iprhpd_checker u_iprhpd_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready)
);

`default_nettype wire

[dv/tb_ipi_rate_halt_poll_decider_unit.sv]
// testbench of the ipi rate halt-poll decider: a directed table, then random batches of samples,
// each result checked in order against a predictor of the batch state or, where given, against
// the table's expectation; depends on iprhpd_pkg and the ipi_rate_halt_poll_decider_unit rtl
`default_nettype none

module tb_ipi_rate_halt_poll_decider_unit;

    localparam int unsigned DataW    = iprhpd_pkg::DataW;
    localparam int unsigned PollW    = iprhpd_pkg::PollW;
    localparam int unsigned CfgW     = iprhpd_pkg::CfgW;
    localparam int unsigned LimitW   = iprhpd_pkg::LimitW;
    localparam int unsigned IdxW     = iprhpd_pkg::IdxW;
    localparam int unsigned InDataW  = iprhpd_pkg::InDataW;
    localparam int unsigned OutDataW = iprhpd_pkg::OutDataW;

    localparam logic KindSample = iprhpd_pkg::KindSample;
    localparam logic KindClear  = iprhpd_pkg::KindClear;

    localparam logic [IdxW-1:0] RegRateThreshold = iprhpd_pkg::RegRateThreshold;
    localparam logic [IdxW-1:0] RegMaxInterval   = iprhpd_pkg::RegMaxInterval;
    localparam logic [IdxW-1:0] RegSampleLimit   = iprhpd_pkg::RegSampleLimit;

    localparam logic [CfgW-1:0]   RstRateThreshold = iprhpd_pkg::RstRateThreshold;
    localparam logic [CfgW-1:0]   RstMaxInterval   = iprhpd_pkg::RstMaxInterval;
    localparam logic [LimitW-1:0] RstSampleLimit   = iprhpd_pkg::RstSampleLimit;

    typedef struct packed {
        logic              accepted;
        logic [DataW-1:0]  peak;
        logic [PollW-1:0]  poll;
        logic              full;
    } t_verdict;

    // expectation typed into the directed table, if any
    typedef struct packed {
        logic     given;
        t_verdict v;
    } t_fixed;

    typedef struct packed {
        logic             kind;
        logic [DataW-1:0] stamp;
        logic [DataW-1:0] count;
        logic             given;
        t_verdict         want;
    } t_script_row;

    localparam t_verdict Blank = '0;
    localparam int NumRows   = 24;
    localparam int NumPhases = 12;
    localparam int PhaseItems = 105;

    localparam logic [DataW-1:0] RateStep [6] = '{32'd20000, 32'd10000, 32'd8000,
                                                 32'd6000, 32'd4000, 32'd2000};
    localparam logic [PollW-1:0] PollStep [6] = '{31'd2000000000, 31'd1000000000,
                                                 31'd500000000, 31'd200000000,
                                                 31'd50000000, 31'd20000000};

    // reset defaults: thr 400, max interval 1000, limit 100
    localparam t_script_row Script [NumRows] = '{
        '{KindClear,  32'd0,          32'd0,          1'b1, Blank},
        '{KindSample, 32'd0,          32'hFFFFFFFF,   1'b1, Blank},
        '{KindSample, 32'd100,        32'd5,          1'b1, Blank},
        '{KindSample, 32'd100,        32'd1,          1'b1, '{1'b1, 32'd0, 31'd0, 1'b0}},
        '{KindSample, 32'd100,        32'd0,          1'b1, Blank},
        '{KindSample, 32'd110,        32'd30000,      1'b1,
            '{1'b1, 32'd3000, 31'd20000000, 1'b0}},
        '{KindSample, 32'd50,         32'hFFFFFFFF,   1'b1,
            '{1'b0, 32'd3000, 31'd20000000, 1'b0}},
        '{KindSample, 32'd1049,       32'hFFFFFFFF,   1'b0, Blank},
        '{KindSample, 32'd2049,       32'hFFFFFFFF,   1'b0, Blank},
        '{KindSample, 32'hFFFFFFFF,   32'd0,          1'b0, Blank},
        '{KindSample, 32'hFFFFFFFF,   32'd1,          1'b0, Blank},
        '{KindClear,  32'hFFFFFFFF,   32'hFFFFFFFF,   1'b1, Blank},
        '{KindSample, 32'd1,          32'd0,          1'b1, Blank},
        '{KindSample, 32'd2,          32'd401,        1'b1, '{1'b1, 32'd401, 31'd0, 1'b0}},
        '{KindSample, 32'd3,          32'd400,        1'b1, '{1'b0, 32'd401, 31'd0, 1'b0}},
        '{KindSample, 32'd4,          32'd2000,       1'b0, Blank},
        '{KindSample, 32'd5,          32'd2001,       1'b0, Blank},
        '{KindSample, 32'd6,          32'd4001,       1'b0, Blank},
        '{KindSample, 32'd7,          32'd6001,       1'b0, Blank},
        '{KindSample, 32'd8,          32'd8001,       1'b0, Blank},
        '{KindSample, 32'd9,          32'd10001,      1'b0, Blank},
        '{KindSample, 32'd10,         32'd20000,      1'b0, Blank},
        '{KindSample, 32'd11,         32'd20001,      1'b0, Blank},
        '{KindSample, 32'd13,         32'd0,          1'b0, Blank}
    };

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic [InDataW-1:0]    i_s_axis_tdata = '0;
    logic                  i_s_axis_tuser = 1'b0;
    logic                  i_s_axis_tvalid = 1'b0;
    logic                  o_s_axis_tready;
    logic [OutDataW-1:0]   o_m_axis_tdata;
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [IdxW-1:0]       i_cfg_idx = '0;
    logic [CfgW-1:0]       i_cfg_data = '0;

    // predictor copy of registers and batch state
    logic [CfgW-1:0]   thr_r;
    logic [CfgW-1:0]   maxint_r;
    logic [LimitW-1:0] limit_r;
    logic [DataW-1:0]  last_stamp_r;
    logic [LimitW-1:0] taken_r;
    logic [DataW-1:0]  peak_r;

    t_verdict verdict_q [$];
    t_fixed   fixed_q [$];
    int       errors = 0;
    int       burst_left = 0;

    int rx_drained = 0;
    int rx_hold = 0;
    int rx_mode = 0;
    int rx_mode_left = 0;
    bit rx_held = 1'b0;

    ipi_rate_halt_poll_decider_unit DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [PollW-1:0] poll_time(input logic [DataW-1:0] rate);
        for (int i = 0; i < 6; i++) begin
            if (rate > RateStep[i]) return PollStep[i];
        end
        return '0;
    endfunction

    // advances the batch state by one request and returns its result
    function automatic t_verdict judge_request(input logic kind, input logic [DataW-1:0] stamp,
                                               input logic [DataW-1:0] count);
        t_verdict         v;
        logic [DataW-1:0] gap;
        logic [63:0]      floor_cnt;
        v = '0;
        if (kind == KindClear) begin
            last_stamp_r = '0;
            taken_r = '0;
            peak_r = '0;
        end else if (taken_r < limit_r) begin
            if (last_stamp_r != 0 && stamp >= last_stamp_r) begin
                gap = stamp - last_stamp_r;
                floor_cnt = thr_r * gap;
                if (gap < maxint_r && {32'd0, count} > floor_cnt) begin
                    v.accepted = 1'b1;
                    taken_r = taken_r + 1'b1;
                    if (gap != 0 && count / gap > peak_r) peak_r = count / gap;
                end
            end
            last_stamp_r = stamp;
        end
        v.peak = peak_r;
        v.poll = poll_time(peak_r);
        v.full = (taken_r >= limit_r);
        return v;
    endfunction

    always @(posedge i_clk) begin
        t_verdict want;
        t_fixed   pin;
        if (!i_rst_n) begin
            thr_r = RstRateThreshold;
            maxint_r = RstMaxInterval;
            limit_r = RstSampleLimit;
            last_stamp_r = '0;
            taken_r = '0;
            peak_r = '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    RegRateThreshold: thr_r = i_cfg_data;
                    RegMaxInterval:   maxint_r = i_cfg_data;
                    RegSampleLimit:   limit_r = i_cfg_data[LimitW-1:0];
                    default: ;
                endcase
            end
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                pin = fixed_q.pop_front();
                want = judge_request(i_s_axis_tuser, i_s_axis_tdata[31:0],
                                     i_s_axis_tdata[63:32]);
                if (pin.given) want = pin.v;
                verdict_q.insert(verdict_q.size(), want);
            end
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                if (verdict_q.size() == 0) begin
                    $error("result with no request pending");
                    errors++;
                end else begin
                    want = verdict_q.pop_front();
                    if (o_m_axis_tdata[0] !== want.accepted) begin
                        $error("accepted: expected %0d, got %0d", want.accepted,
                               o_m_axis_tdata[0]);
                        errors++;
                    end
                    if (o_m_axis_tdata[32:1] !== want.peak) begin
                        $error("peak_rate: expected %0d, got %0d", want.peak,
                               o_m_axis_tdata[32:1]);
                        errors++;
                    end
                    if (o_m_axis_tdata[63:33] !== want.poll) begin
                        $error("poll_ns: expected %0d, got %0d", want.poll,
                               o_m_axis_tdata[63:33]);
                        errors++;
                    end
                    if (o_m_axis_tdata[64] !== want.full) begin
                        $error("batch_full: expected %0d, got %0d", want.full,
                               o_m_axis_tdata[64]);
                        errors++;
                    end
                    if (o_m_axis_tdata[71:65] !== '0) begin
                        $error("padding: expected 0, got %0h", o_m_axis_tdata[71:65]);
                        errors++;
                    end
                end
            end
        end
    end

    // result side: changing stall patterns, and one long hold-off to back up the input
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else begin
            if (o_m_axis_tvalid && i_m_axis_tready) rx_drained++;
            if (rx_hold != 0) begin
                rx_hold--;
                i_m_axis_tready <= 1'b0;
            end else if (!rx_held && rx_drained >= 300) begin
                rx_held = 1'b1;
                rx_hold = 400;
                i_m_axis_tready <= 1'b0;
            end else begin
                if (rx_mode_left == 0) begin
                    rx_mode = $urandom_range(0, 3);
                    rx_mode_left = $urandom_range(20, 200);
                end
                rx_mode_left--;
                case (rx_mode)
                    0: i_m_axis_tready <= 1'b1;
                    1: i_m_axis_tready <= $urandom_range(0, 1);
                    2: i_m_axis_tready <= ($urandom_range(0, 3) == 0);
                    default: i_m_axis_tready <= (rx_mode_left % 5 != 0);
                endcase
            end
        end
    end

    task automatic put_request(input logic kind, input logic [DataW-1:0] stamp,
                               input logic [DataW-1:0] count, input logic given,
                               input t_verdict want);
        t_fixed pin;
        if (burst_left == 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 6))
                @(posedge i_clk);
            burst_left = $urandom_range(1, 32);
        end
        burst_left--;
        pin.given = given;
        pin.v = want;
        fixed_q.insert(fixed_q.size(), pin);
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser <= kind;
        i_s_axis_tdata <= {count, stamp};
        do @(posedge i_clk); while (!o_s_axis_tready);
    endtask

    task automatic drain_results();
        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (verdict_q.size() != 0) @(posedge i_clk);
        repeat (45) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [IdxW-1:0] idx, input logic [CfgW-1:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
    endtask

    initial begin
        int                sel;
        int                pick;
        int                sends;
        int                clear_pct;
        int                iv;
        logic              kind_v;
        logic [DataW-1:0]  st_v;
        logic [DataW-1:0]  cnt_v;
        logic [DataW-1:0]  gap_v;
        logic [DataW-1:0]  rate_v;
        logic [DataW-1:0]  sent_stamp;
        longint unsigned   total;
        longint unsigned   extra;
        logic [CfgW-1:0]   cfg_thr;
        logic [CfgW-1:0]   cfg_maxint;
        logic [LimitW-1:0] cfg_limit;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int row = 0; row < NumRows; row++) begin
            put_request(Script[row].kind, Script[row].stamp, Script[row].count,
                        Script[row].given, Script[row].want);
        end

        sent_stamp = '0;
        for (int ph = 0; ph < NumPhases; ph++) begin
            case (ph)
                0: begin cfg_thr = 16'hFFFF; cfg_maxint = 16'hFFFF; cfg_limit = 7'd127; end
                1: begin cfg_thr = 16'd0; cfg_maxint = 16'd1; cfg_limit = 7'd1; end
                2: begin cfg_thr = 16'd0; cfg_maxint = 16'd0; cfg_limit = 7'd0; end
                default: begin
                    case ($urandom_range(0, 5))
                        0: cfg_thr = 16'd0;
                        1: cfg_thr = 16'd1;
                        2: cfg_thr = 16'd400;
                        3: cfg_thr = 16'hFFFF;
                        4: cfg_thr = $urandom_range(0, 65535);
                        default: cfg_thr = $urandom_range(1, 3000);
                    endcase
                    case ($urandom_range(0, 6))
                        0: cfg_maxint = 16'd0;
                        1: cfg_maxint = 16'd1;
                        2: cfg_maxint = 16'd2;
                        3: cfg_maxint = 16'd1000;
                        4: cfg_maxint = 16'hFFFF;
                        5: cfg_maxint = $urandom_range(1, 65535);
                        default: cfg_maxint = $urandom_range(2, 50);
                    endcase
                    case ($urandom_range(0, 6))
                        0: cfg_limit = 7'd0;
                        1: cfg_limit = 7'd1;
                        2: cfg_limit = 7'd2;
                        3: cfg_limit = 7'd5;
                        4: cfg_limit = 7'd100;
                        5: cfg_limit = 7'd127;
                        default: cfg_limit = $urandom_range(1, 127);
                    endcase
                end
            endcase

            drain_results();
            write_reg(RegRateThreshold, cfg_thr);
            write_reg(RegMaxInterval, cfg_maxint);
            write_reg(RegSampleLimit, {{(CfgW-LimitW){1'b0}}, cfg_limit});
            i_cfg_we <= 1'b0;

            // small batches fill fast, so clear them more often
            clear_pct = (cfg_limit <= 3) ? 25 : 4;
            sends = 0;
            while (sends < PhaseItems) begin
                sel = $urandom_range(0, 99);
                kind_v = KindSample;
                if (sel < clear_pct) begin
                    kind_v = KindClear;
                    st_v = $urandom();
                    cnt_v = $urandom();
                    sent_stamp = '0;
                end else if (sel < clear_pct + 8) begin
                    st_v = $urandom();
                    cnt_v = $urandom();
                end else if (sel < clear_pct + 12) begin
                    // zero stamp or time going backward
                    st_v = ($urandom_range(0, 1) == 0) ? 32'd0
                                                      : sent_stamp - $urandom_range(1, 50);
                    cnt_v = $urandom();
                end else begin
                    if (sent_stamp == 0) begin
                        st_v = $urandom_range(1, 32'h7FFFFFFF);
                    end else begin
                        pick = $urandom_range(0, 99);
                        if (pick < 55) iv = $urandom_range(1, 6);
                        else if (pick < 65) iv = 0;
                        else if (pick < 85) iv = $urandom_range(0, cfg_maxint + 1);
                        else iv = cfg_maxint + $urandom_range(0, 2) - 1;
                        st_v = sent_stamp + iv;
                    end
                    gap_v = st_v - sent_stamp;
                    extra = (gap_v == 0) ? $urandom_range(0, 3) : $urandom_range(0, gap_v - 1);
                    case ($urandom_range(0, 3))
                        0: begin
                            // right at the threshold or one above it
                            rate_v = cfg_thr;
                            extra = $urandom_range(0, 1);
                        end
                        1: rate_v = RateStep[$urandom_range(0, 5)] + $urandom_range(0, 1);
                        2: rate_v = $urandom_range(0, 30000);
                        default: rate_v = $urandom();
                    endcase
                    total = longint'(rate_v) * longint'(gap_v) + extra;
                    cnt_v = (total > 64'hFFFFFFFF) ? 32'hFFFFFFFF : total[31:0];
                end
                if (kind_v == KindSample) sent_stamp = st_v;
                put_request(kind_v, st_v, cnt_v, 1'b0, Blank);
                sends++;
            end
        end

        drain_results();
        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #12_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

`default_nettype wire
